// ===== rtl/rsld_pkg.sv =====
`timescale 1ns / 1ps

package rsld_pkg;

  localparam int HwLeds          = 4;
  localparam int LedCountDefault = 4;
  localparam int LedIdxW         = 2;
  localparam int ColorW          = 2;
  localparam int ChanW           = 4;
  localparam int DutyW           = 12;
  localparam int PctW            = 7;
  localparam int TimeW           = 32;
  localparam int IntervalW       = 16;
  localparam int BrightW         = 8;
  localparam int CfgDataW        = 16;
  localparam int ProdW           = DutyW + PctW;

  localparam logic [BrightW-1:0] PctMin = 8'd5;
  localparam logic [BrightW-1:0] PctMax = 8'd100;

  // Division by 100 is done as a multiplication by ceil(2^26 / 100) and a shift.
  // The error stays below one for every product the unit can see.
  localparam int               RecipShift = 26;
  localparam int               RecipW     = 20;
  localparam logic [RecipW-1:0] Recip100  = 20'd671089;

  localparam logic [PctW-1:0] ScaleNone   = 7'd100;
  localparam logic [PctW-1:0] ScaleRed    = 7'd80;
  localparam logic [PctW-1:0] ScaleYellow = 7'd60;

  localparam logic [DutyW-1:0] DutyFull = 12'd4095;
  localparam logic [DutyW-1:0] DutyHalf = 12'd2048;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_SET,
    OP_POWER,
    OP_GPS,
    OP_STEER,
    OP_IMU,
    OP_REFRESH,
    OP_NONE
  } op_e;

  typedef enum logic [ColorW-1:0] {
    COL_OFF,
    COL_RED,
    COL_YELLOW,
    COL_GREEN
  } color_e;

  typedef enum logic [0:0] {
    CFG_BRIGHTNESS,
    CFG_INTERVAL
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_CALC,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    STEP_RED_BRIGHT,
    STEP_RED_SCALE,
    STEP_GREEN_BRIGHT,
    STEP_GREEN_SCALE
  } step_e;

  typedef struct packed {
    logic               en;
    logic [LedIdxW-1:0] idx;
    color_e             color;
    logic               mode;
  } set_cmd_t;

  typedef struct packed {
    logic               en;
    logic [LedIdxW-1:0] idx;
    logic [TimeW-1:0]   now;
  } tick_cmd_t;

  typedef struct packed {
    color_e           color;
    logic             mode;
    logic             phase;
    logic [TimeW-1:0] last;
  } led_state_t;

  // Turns a set or status item into the write it makes on the LED store.
  function automatic set_cmd_t map_item(op_e op, logic [LedIdxW-1:0] idx,
                                        logic [ColorW-1:0] color, logic mode,
                                        logic [7:0] fq, logic a, logic b, logic c);
    set_cmd_t cmd;
    cmd = '{en: 1'b1, idx: idx, color: color_e'(color), mode: mode};
    case (op)
      OP_SET: begin
      end
      OP_POWER: begin
        cmd.idx = 2'd0;
        if (!a) begin
          cmd.color = COL_RED;    cmd.mode = 1'b0;
        end else if (!b) begin
          cmd.color = COL_YELLOW; cmd.mode = 1'b1;
        end else begin
          cmd.color = COL_GREEN;  cmd.mode = 1'b0;
        end
      end
      OP_GPS: begin
        cmd.idx  = 2'd1;
        cmd.mode = 1'b0;
        if (!a) begin
          cmd.color = COL_OFF;
        end else if (fq == 8'd0) begin
          cmd.color = COL_RED;
        end else if (fq == 8'd4) begin
          cmd.color = COL_GREEN;
        end else if (fq == 8'd5) begin
          cmd.color = COL_YELLOW; cmd.mode = 1'b1;
        end else begin
          cmd.color = COL_YELLOW;
        end
      end
      OP_STEER: begin
        cmd.idx  = 2'd2;
        cmd.mode = 1'b0;
        if (!a) begin
          cmd.color = COL_OFF;
        end else if (!b) begin
          cmd.color = COL_YELLOW;
        end else if (!c) begin
          cmd.color = COL_GREEN; cmd.mode = 1'b1;
        end else begin
          cmd.color = COL_GREEN;
        end
      end
      OP_IMU: begin
        cmd.idx  = 2'd3;
        cmd.mode = 1'b0;
        if (!a) begin
          cmd.color = COL_OFF;
        end else if (!b) begin
          cmd.color = COL_RED; cmd.mode = 1'b1;
        end else if (!c) begin
          cmd.color = COL_YELLOW;
        end else begin
          cmd.color = COL_GREEN;
        end
      end
      default: begin
        cmd.en = 1'b0;
      end
    endcase
    return cmd;
  endfunction

  function automatic logic [DutyW-1:0] base_red(color_e c);
    case (c)
      COL_RED, COL_YELLOW: return DutyFull;
      default:             return '0;
    endcase
  endfunction

  function automatic logic [DutyW-1:0] base_green(color_e c);
    case (c)
      COL_YELLOW: return DutyHalf;
      COL_GREEN:  return DutyFull;
      default:    return '0;
    endcase
  endfunction

  function automatic logic [PctW-1:0] scale_red(color_e c);
    case (c)
      COL_RED:    return ScaleRed;
      COL_YELLOW: return ScaleYellow;
      default:    return ScaleNone;
    endcase
  endfunction

  function automatic logic [PctW-1:0] scale_green(color_e c);
    case (c)
      COL_YELLOW: return ScaleYellow;
      default:    return ScaleNone;
    endcase
  endfunction

  function automatic logic [ChanW-1:0] red_pin(logic [LedIdxW-1:0] i);
    case (i)
      2'd0:    return 4'd13;
      2'd1:    return 4'd5;
      2'd2:    return 4'd1;
      default: return 4'd6;
    endcase
  endfunction

  function automatic logic [ChanW-1:0] green_pin(logic [LedIdxW-1:0] i);
    case (i)
      2'd0:    return 4'd14;
      2'd1:    return 4'd7;
      2'd2:    return 4'd0;
      default: return 4'd4;
    endcase
  endfunction

  function automatic logic [ChanW-1:0] blue_pin(logic [LedIdxW-1:0] i);
    case (i)
      2'd0:    return 4'd15;
      2'd1:    return 4'd12;
      2'd2:    return 4'd3;
      default: return 4'd2;
    endcase
  endfunction

endpackage

// ===== rtl/rsld_scale.sv =====
`timescale 1ns / 1ps

module rsld_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rsld_pkg::DutyW-1:0]  x_i,
  input  logic [rsld_pkg::PctW-1:0]   f_i,
  output logic                        done_o,
  output logic [rsld_pkg::DutyW-1:0]  y_o
);
  import rsld_pkg::*;

  localparam int QuotW = ProdW + RecipW;

  logic                     p_valid_q;
  logic [ProdW-1:0]         p_q;
  logic                     y_valid_q;
  logic [DutyW-1:0]         y_q;
  logic [QuotW-1:0]         quot_full;

  // floor(p / 100) of the registered product, by reciprocal multiplication.
  assign quot_full = QuotW'(p_q) * QuotW'(Recip100);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      y_valid_q <= 1'b0;
    end else begin
      p_valid_q <= start_i;
      y_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= ProdW'(x_i) * ProdW'(f_i);
    y_q <= quot_full[RecipShift +: DutyW];
  end

  assign done_o = y_valid_q;
  assign y_o    = y_q;

endmodule

// ===== rtl/rsld_led_store.sv =====
`timescale 1ns / 1ps

module rsld_led_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rsld_pkg::set_cmd_t           set_i,
  input  rsld_pkg::tick_cmd_t          tick_i,
  input  logic [rsld_pkg::LedIdxW-1:0] rd_idx_i,
  output rsld_pkg::led_state_t         rd_o
);
  import rsld_pkg::*;

  color_e           color_q [HwLeds];
  logic             mode_q  [HwLeds];
  logic             phase_q [HwLeds];
  logic [TimeW-1:0] last_q  [HwLeds];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HwLeds; i++) begin
        color_q[i] <= COL_OFF;
        mode_q[i]  <= 1'b0;
        phase_q[i] <= 1'b0;
        last_q[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < HwLeds; i++) begin
        if (set_i.en && set_i.idx == LedIdxW'(i)) begin
          color_q[i] <= set_i.color;
          mode_q[i]  <= set_i.mode;
          // Going solid forgets the blink phase; going blinking keeps it.
          if (!set_i.mode) begin
            phase_q[i] <= 1'b0;
          end
        end
        if (tick_i.en && tick_i.idx == LedIdxW'(i)) begin
          phase_q[i] <= ~phase_q[i];
          last_q[i]  <= tick_i.now;
        end
      end
    end
  end

  assign rd_o = '{color: color_q[rd_idx_i], mode: mode_q[rd_idx_i],
                  phase: phase_q[rd_idx_i], last: last_q[rd_idx_i]};

endmodule

// ===== rtl/rgb_status_led_blink_dimmer.sv =====
`timescale 1ns / 1ps
// Each LED update picks the LED, makes four passes through the shared multiply and
// divide-by-100 unit, and presents the result until the receiver takes it.
// A set or status item makes at most one update and a refresh one per fitted LED; a tick
// first compares times for each fitted LED in turn, then updates each LED that toggles.
// Input is taken only while idle. Reset is asynchronous: all LEDs off and solid,
// phases and toggle times zero, brightness 100 and interval 500; no clearing pass.
module rgb_status_led_blink_dimmer #(
  parameter int LED_COUNT = rsld_pkg::LedCountDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_index_i,
  input  logic [rsld_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     op_i,
  input  logic [rsld_pkg::LedIdxW-1:0]   led_index_i,
  input  logic [rsld_pkg::ColorW-1:0]    color_i,
  input  logic                           mode_i,
  input  logic [rsld_pkg::TimeW-1:0]     now_ms_i,
  input  logic [7:0]                     fix_quality_i,
  input  logic                           flag_a_i,
  input  logic                           flag_b_i,
  input  logic                           flag_c_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rsld_pkg::LedIdxW-1:0]   led_number_o,
  output logic [rsld_pkg::ChanW-1:0]     red_channel_o,
  output logic [rsld_pkg::ChanW-1:0]     green_channel_o,
  output logic [rsld_pkg::ChanW-1:0]     blue_channel_o,
  output logic [rsld_pkg::DutyW-1:0]     red_duty_o,
  output logic [rsld_pkg::DutyW-1:0]     green_duty_o,
  output logic [rsld_pkg::DutyW-1:0]     blue_duty_o,
  output logic                           last_of_run_o
);
  import rsld_pkg::*;

  localparam int                  NumLeds = (LED_COUNT < HwLeds) ? LED_COUNT : HwLeds;
  localparam logic [HwLeds-1:0]   OkMask  = HwLeds'((1 << NumLeds) - 1);
  localparam logic [LedIdxW-1:0]  LastLed = LedIdxW'(NumLeds - 1);

  state_e                 state_q, state_d;
  logic [HwLeds-1:0]      mask_q, mask_d;
  logic [LedIdxW-1:0]     cur_q, cur_d;
  logic [LedIdxW-1:0]     scan_q, scan_d;
  logic [TimeW-1:0]       now_q, now_d;
  logic                   last_q, last_d;
  step_e                  step_q, step_d;
  logic                   busy_q, busy_d;
  logic [DutyW-1:0]       red_q, red_d;
  logic [DutyW-1:0]       green_q, green_d;
  logic [BrightW-1:0]     bright_q;
  logic [IntervalW-1:0]   interval_q;

  logic                   in_accept;
  set_cmd_t               mapped;
  set_cmd_t               set_cmd;
  tick_cmd_t              tick_cmd;
  logic [LedIdxW-1:0]     rd_idx;
  led_state_t             st;
  logic [TimeW-1:0]       elapsed;
  logic                   hit;
  logic                   lit;
  color_e                 col_eff;
  logic [PctW-1:0]        bright_pct;
  logic                   unit_start;
  logic [DutyW-1:0]       unit_x;
  logic [PctW-1:0]        unit_f;
  logic                   unit_done;
  logic [DutyW-1:0]       unit_y;
  logic [LedIdxW-1:0]     pick_idx;
  logic [HwLeds-1:0]      pick_rest;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q   <= PctMax;
      interval_q <= 16'd500;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_BRIGHTNESS: bright_q   <= cfg_wdata_i[BrightW-1:0];
        CFG_INTERVAL:   interval_q <= cfg_wdata_i[IntervalW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (bright_q < PctMin) begin
      bright_pct = PctMin[PctW-1:0];
    end else if (bright_q > PctMax) begin
      bright_pct = PctMax[PctW-1:0];
    end else begin
      bright_pct = bright_q[PctW-1:0];
    end
  end

  assign in_accept = in_valid_i && !in_stall_o;
  assign mapped    = map_item(op_e'(op_i), led_index_i, color_i, mode_i,
                              fix_quality_i, flag_a_i, flag_b_i, flag_c_i);

  assign rd_idx  = (state_q == ST_SCAN) ? scan_q : cur_q;
  assign elapsed = now_q - st.last;
  assign hit     = st.mode && (elapsed >= {{(TimeW-IntervalW){1'b0}}, interval_q});
  assign lit     = !st.mode || st.phase;
  assign col_eff = lit ? st.color : COL_OFF;

  // Lowest pending LED goes first.
  always_comb begin
    pick_idx = '0;
    for (int i = HwLeds - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        pick_idx = LedIdxW'(i);
      end
    end
    pick_rest = mask_q & ~(HwLeds'(1) << pick_idx);
  end

  always_comb begin
    case (step_q)
      STEP_RED_BRIGHT: begin
        unit_x = base_red(col_eff);   unit_f = bright_pct;
      end
      STEP_RED_SCALE: begin
        unit_x = red_q;               unit_f = scale_red(col_eff);
      end
      STEP_GREEN_BRIGHT: begin
        unit_x = base_green(col_eff); unit_f = bright_pct;
      end
      default: begin
        unit_x = green_q;             unit_f = scale_green(col_eff);
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    mask_d     = mask_q;
    cur_d      = cur_q;
    scan_d     = scan_q;
    now_d      = now_q;
    last_d     = last_q;
    step_d     = step_q;
    busy_d     = busy_q;
    red_d      = red_q;
    green_d    = green_q;
    set_cmd    = '{en: 1'b0, idx: '0, color: COL_OFF, mode: 1'b0};
    tick_cmd   = '{en: 1'b0, idx: scan_q, now: now_q};
    unit_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          now_d = now_ms_i;
          case (op_e'(op_i))
            OP_TICK: begin
              scan_d  = '0;
              mask_d  = '0;
              state_d = ST_SCAN;
            end
            OP_REFRESH: begin
              mask_d  = OkMask;
              state_d = ST_PICK;
            end
            default: begin
              // A target beyond the fitted LEDs leaves the store untouched.
              if (mapped.en && OkMask[mapped.idx]) begin
                set_cmd = mapped;
                mask_d  = HwLeds'(1) << mapped.idx;
              end
              state_d = ST_PICK;
            end
          endcase
        end
      end
      ST_SCAN: begin
        tick_cmd.en = hit;
        if (hit) begin
          mask_d[scan_q] = 1'b1;
        end
        if (scan_q == LastLed) begin
          state_d = ST_PICK;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_PICK: begin
        if (mask_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          cur_d   = pick_idx;
          mask_d  = pick_rest;
          last_d  = (pick_rest == '0);
          step_d  = STEP_RED_BRIGHT;
          busy_d  = 1'b0;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (!busy_q) begin
          unit_start = 1'b1;
          busy_d     = 1'b1;
        end else if (unit_done) begin
          busy_d = 1'b0;
          if (step_q == STEP_RED_BRIGHT || step_q == STEP_RED_SCALE) begin
            red_d = unit_y;
          end else begin
            green_d = unit_y;
          end
          if (step_q == STEP_GREEN_SCALE) begin
            state_d = ST_OUT;
          end else begin
            step_d = step_e'(step_q + 1'b1);
          end
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = last_q ? ST_IDLE : ST_PICK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mask_q  <= '0;
      scan_q  <= '0;
      step_q  <= STEP_RED_BRIGHT;
      busy_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mask_q  <= mask_d;
      scan_q  <= scan_d;
      step_q  <= step_d;
      busy_q  <= busy_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    now_q   <= now_d;
    red_q   <= red_d;
    green_q <= green_d;
  end

  rsld_led_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .set_i    (set_cmd),
    .tick_i   (tick_cmd),
    .rd_idx_i (rd_idx),
    .rd_o     (st)
  );

  rsld_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .x_i     (unit_x),
    .f_i     (unit_f),
    .done_o  (unit_done),
    .y_o     (unit_y)
  );

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = (state_q == ST_OUT);
  assign led_number_o    = cur_q;
  assign red_channel_o   = red_pin(cur_q);
  assign green_channel_o = green_pin(cur_q);
  assign blue_channel_o  = blue_pin(cur_q);
  assign red_duty_o      = red_q;
  assign green_duty_o    = green_q;
  assign blue_duty_o     = '0;
  assign last_of_run_o   = last_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("block took a transaction but did not go busy");

  a_unit_only_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_done |-> (state_q == ST_CALC && busy_q))
    else $error("scaling unit finished outside a calculation step");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_run_o && !out_stall_i) |=> (!out_valid_o && mask_q == '0))
    else $error("updates continued after the final one of a transaction");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (mask_q == '0))
    else $error("LED updates left pending while idle");
`endif

endmodule

// ===== tb/sv/rgb_status_led_blink_dimmer_tb.sv =====
`timescale 1ns / 1ps

module rgb_status_led_blink_dimmer_tb;
  import rsld_pkg::*;

  localparam int QuietLimit   = 2000;
  localparam int SettleCycles = 100;
  localparam int RandomItems  = 85;
  localparam int PhaseCount   = 6;

  localparam logic [ChanW-1:0] RedPins   [HwLeds] = '{4'd13, 4'd5,  4'd1, 4'd6};
  localparam logic [ChanW-1:0] GreenPins [HwLeds] = '{4'd14, 4'd7,  4'd0, 4'd4};
  localparam logic [ChanW-1:0] BluePins  [HwLeds] = '{4'd15, 4'd12, 4'd3, 4'd2};

  typedef struct {
    op_e                op;
    logic [LedIdxW-1:0] led_index;
    color_e             color;
    logic               mode;
    logic [TimeW-1:0]   now_ms;
    logic [7:0]         fix_quality;
    logic               flag_a;
    logic               flag_b;
    logic               flag_c;
  } led_item_t;

  typedef struct {
    logic [LedIdxW-1:0] led_number;
    logic [ChanW-1:0]   red_channel;
    logic [ChanW-1:0]   green_channel;
    logic [ChanW-1:0]   blue_channel;
    logic [DutyW-1:0]   red_duty;
    logic [DutyW-1:0]   green_duty;
    logic [DutyW-1:0]   blue_duty;
    logic               last_of_run;
  } led_update_t;

  class led_duty_scoreboard;
    color_e             stored_colour [HwLeds];
    logic               blinking    [HwLeds];
    logic               phase       [HwLeds];
    logic [TimeW-1:0]   last_toggle [HwLeds];
    logic [BrightW-1:0] brightness;
    logic [IntervalW-1:0] interval;
    led_update_t        pending_updates[$];
    int                 errors;

    function new();
      brightness = 8'd100;
      interval   = 16'd500;
      errors     = 0;
      for (int i = 0; i < HwLeds; i++) begin
        stored_colour[i] = COL_OFF;
        blinking[i]    = 1'b0;
        phase[i]       = 1'b0;
        last_toggle[i] = '0;
      end
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_BRIGHTNESS: brightness = data[BrightW-1:0];
        default:        interval   = data[IntervalW-1:0];
      endcase
    endfunction

    function led_update_t led_duty(int i);
      led_update_t u;
      int unsigned pct;
      int unsigned r;
      int unsigned g;
      pct = brightness;
      if (pct < 5) pct = 5;
      if (pct > 100) pct = 100;
      r = 0;
      g = 0;
      // A blinking LED is dark in the off half of its cycle.
      if ((!blinking[i] || phase[i]) && stored_colour[i] != COL_OFF) begin
        case (stored_colour[i])
          COL_RED: begin
            r = 4095 * pct / 100;
            r = r * 80 / 100;
          end
          COL_YELLOW: begin
            r = 4095 * pct / 100;
            r = r * 60 / 100;
            g = 2048 * pct / 100;
            g = g * 60 / 100;
          end
          default: begin
            g = 4095 * pct / 100;
          end
        endcase
      end
      u.led_number    = LedIdxW'(i);
      u.red_channel   = RedPins[i];
      u.green_channel = GreenPins[i];
      u.blue_channel  = BluePins[i];
      u.red_duty      = DutyW'(r);
      u.green_duty    = DutyW'(g);
      u.blue_duty     = '0;
      u.last_of_run   = 1'b0;
      return u;
    endfunction

    function led_update_t store_led(int i, color_e c, logic m);
      stored_colour[i] = c;
      blinking[i]  = m;
      if (!m) phase[i] = 1'b0;
      return led_duty(i);
    endfunction

    function void note_item(led_item_t it);
      led_update_t run[$];
      logic [TimeW-1:0] elapsed;
      case (it.op)
        OP_TICK: begin
          for (int i = 0; i < HwLeds; i++) begin
            elapsed = it.now_ms - last_toggle[i];
            if (blinking[i] && elapsed >= {16'd0, interval}) begin
              phase[i]       = ~phase[i];
              last_toggle[i] = it.now_ms;
              run.push_back(led_duty(i));
            end
          end
        end
        OP_SET: run.push_back(store_led(it.led_index, it.color, it.mode));
        OP_POWER: begin
          if (!it.flag_a)      run.push_back(store_led(0, COL_RED, 1'b0));
          else if (!it.flag_b) run.push_back(store_led(0, COL_YELLOW, 1'b1));
          else                 run.push_back(store_led(0, COL_GREEN, 1'b0));
        end
        OP_GPS: begin
          if (!it.flag_a)                 run.push_back(store_led(1, COL_OFF, 1'b0));
          else if (it.fix_quality == 0)   run.push_back(store_led(1, COL_RED, 1'b0));
          else if (it.fix_quality == 4)   run.push_back(store_led(1, COL_GREEN, 1'b0));
          else if (it.fix_quality == 5)   run.push_back(store_led(1, COL_YELLOW, 1'b1));
          else                            run.push_back(store_led(1, COL_YELLOW, 1'b0));
        end
        OP_STEER: begin
          if (!it.flag_a)      run.push_back(store_led(2, COL_OFF, 1'b0));
          else if (!it.flag_b) run.push_back(store_led(2, COL_YELLOW, 1'b0));
          else if (!it.flag_c) run.push_back(store_led(2, COL_GREEN, 1'b1));
          else                 run.push_back(store_led(2, COL_GREEN, 1'b0));
        end
        OP_IMU: begin
          if (!it.flag_a)      run.push_back(store_led(3, COL_OFF, 1'b0));
          else if (!it.flag_b) run.push_back(store_led(3, COL_RED, 1'b1));
          else if (!it.flag_c) run.push_back(store_led(3, COL_YELLOW, 1'b0));
          else                 run.push_back(store_led(3, COL_GREEN, 1'b0));
        end
        OP_REFRESH: begin
          for (int i = 0; i < HwLeds; i++) run.push_back(led_duty(i));
        end
        default: begin
        end
      endcase
      if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
      foreach (run[k]) pending_updates.push_back(run[k]);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_update(led_update_t got);
      led_update_t want;
      if (pending_updates.size() == 0) begin
        $error("LED update for LED %0d arrived with none outstanding", got.led_number);
        errors++;
        return;
      end
      want = pending_updates.pop_front();
      compare_field("led_number", want.led_number, got.led_number);
      compare_field("red_channel", want.red_channel, got.red_channel);
      compare_field("green_channel", want.green_channel, got.green_channel);
      compare_field("blue_channel", want.blue_channel, got.blue_channel);
      compare_field("red_duty", want.red_duty, got.red_duty);
      compare_field("green_duty", want.green_duty, got.green_duty);
      compare_field("blue_duty", want.blue_duty, got.blue_duty);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [0:0]          cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [2:0]          op_i;
  logic [LedIdxW-1:0]  led_index_i;
  logic [ColorW-1:0]   color_i;
  logic                mode_i;
  logic [TimeW-1:0]    now_ms_i;
  logic [7:0]          fix_quality_i;
  logic                flag_a_i;
  logic                flag_b_i;
  logic                flag_c_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [LedIdxW-1:0]  led_number_o;
  logic [ChanW-1:0]    red_channel_o;
  logic [ChanW-1:0]    green_channel_o;
  logic [ChanW-1:0]    blue_channel_o;
  logic [DutyW-1:0]    red_duty_o;
  logic [DutyW-1:0]    green_duty_o;
  logic [DutyW-1:0]    blue_duty_o;
  logic                last_of_run_o;

  led_duty_scoreboard sb = new();
  logic [TimeW-1:0]   clock_ms;
  int                 stall_hold = 0;
  int                 quiet_cycles = 0;

  rgb_status_led_blink_dimmer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .led_index_i    (led_index_i),
    .color_i        (color_i),
    .mode_i         (mode_i),
    .now_ms_i       (now_ms_i),
    .fix_quality_i  (fix_quality_i),
    .flag_a_i       (flag_a_i),
    .flag_b_i       (flag_b_i),
    .flag_c_i       (flag_c_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .led_number_o   (led_number_o),
    .red_channel_o  (red_channel_o),
    .green_channel_o(green_channel_o),
    .blue_channel_o (blue_channel_o),
    .red_duty_o     (red_duty_o),
    .green_duty_o   (green_duty_o),
    .blue_duty_o    (blue_duty_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #1 clk_i = ~clk_i;

  // Receiver back-pressure: mostly short bursts, now and then a long stall or a free run.
  always @(posedge clk_i) begin
    int pick;
    if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        out_stall_i <= 1'b0;
        stall_hold  = $urandom_range(0, 7);
      end else if (pick < 7) begin
        out_stall_i <= 1'b1;
        stall_hold  = $urandom_range(0, 2);
      end else if (pick < 8) begin
        out_stall_i <= 1'b1;
        stall_hold  = $urandom_range(15, 40);
      end else begin
        out_stall_i <= 1'b0;
        stall_hold  = $urandom_range(30, 80);
      end
    end
  end

  always @(posedge clk_i) begin
    led_update_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.led_number    = led_number_o;
        got.red_channel   = red_channel_o;
        got.green_channel = green_channel_o;
        got.blue_channel  = blue_channel_o;
        got.red_duty      = red_duty_o;
        got.green_duty    = green_duty_o;
        got.blue_duty     = blue_duty_o;
        got.last_of_run   = last_of_run_o;
        sb.check_update(got);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic led_item_t make_item(op_e op, logic [LedIdxW-1:0] idx, color_e c,
                                          logic m, logic [TimeW-1:0] now,
                                          logic [7:0] fq, logic fa, logic fb, logic fc);
    led_item_t it;
    it.op          = op;
    it.led_index   = idx;
    it.color       = c;
    it.mode        = m;
    it.now_ms      = now;
    it.fix_quality = fq;
    it.flag_a      = fa;
    it.flag_b      = fb;
    it.flag_c      = fc;
    return it;
  endfunction

  // Holds the transaction until the block takes it; valid stays high for a
  // following item when no gap comes between them.
  task automatic send_item(led_item_t it);
    in_valid_i    <= 1'b1;
    op_i          <= it.op;
    led_index_i   <= it.led_index;
    color_i       <= it.color;
    mode_i        <= it.mode;
    now_ms_i      <= it.now_ms;
    fix_quality_i <= it.fix_quality;
    flag_a_i      <= it.flag_a;
    flag_b_i      <= it.flag_b;
    flag_c_i      <= it.flag_c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(it);
  endtask

  task automatic sender_gap();
    int pick;
    int gap;
    pick = $urandom_range(0, 9);
    if (pick < 6) gap = 0;
    else if (pick < 9) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_updates.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // The upper byte of a brightness write is random; only the low byte counts.
  task automatic set_levels(logic [BrightW-1:0] bright, logic [IntervalW-1:0] ivl);
    write_reg(CFG_BRIGHTNESS, {8'($urandom_range(0, 255)), bright});
    write_reg(CFG_INTERVAL, ivl);
  endtask

  task automatic random_item(output led_item_t it);
    int pick;
    int unsigned span;
    pick = $urandom_range(0, 9);
    if (pick < 3)      it.fix_quality = 8'd0;
    else if (pick < 5) it.fix_quality = 8'd4;
    else if (pick < 7) it.fix_quality = 8'd5;
    else               it.fix_quality = 8'($urandom_range(0, 255));
    it.led_index = LedIdxW'($urandom_range(0, 3));
    it.color     = color_e'($urandom_range(0, 3));
    it.mode      = 1'($urandom_range(0, 1));
    it.flag_a    = ($urandom_range(0, 3) != 0);
    it.flag_b    = ($urandom_range(0, 3) != 0);
    it.flag_c    = ($urandom_range(0, 3) != 0);
    it.now_ms    = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.op = OP_TICK;
      span  = sb.interval;
      pick  = $urandom_range(0, 9);
      if (pick < 6)      clock_ms = clock_ms + $urandom_range(0, 2 * span);
      else if (pick < 8) clock_ms = clock_ms + span;
      else if (pick < 9) clock_ms = clock_ms + span - 1;
      else               clock_ms = $urandom;
      it.now_ms = clock_ms;
    end else if (pick < 80) begin
      it.op = op_e'($urandom_range(OP_SET, OP_IMU));
    end else if (pick < 93) begin
      it.op = OP_REFRESH;
    end else begin
      it.op = OP_NONE;
    end
  endtask

  initial begin
    led_item_t it;
    int sent;
    logic [BrightW-1:0]   bright;
    logic [IntervalW-1:0] ivl;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_BRIGHTNESS;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    op_i          <= OP_TICK;
    led_index_i   <= '0;
    color_i       <= COL_OFF;
    mode_i        <= 1'b0;
    now_ms_i      <= '0;
    fix_quality_i <= '0;
    flag_a_i      <= 1'b0;
    flag_b_i      <= 1'b0;
    flag_c_i      <= 1'b0;
    clock_ms      = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state, every colour and mode through direct sets.
    send_item(make_item(OP_REFRESH, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    sender_gap();
    send_item(make_item(OP_SET, 2'd0, COL_RED, 1'b0, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_SET, 2'd1, COL_YELLOW, 1'b0, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    sender_gap();
    send_item(make_item(OP_SET, 2'd2, COL_GREEN, 1'b0, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_SET, 2'd3, COL_GREEN, 1'b1, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    // Ticks just short of and at the interval, then across the 32-bit wrap.
    send_item(make_item(OP_TICK, 2'd0, COL_OFF, 1'b0, 32'd499, 8'd0, 1'b0, 1'b0, 1'b0));
    sender_gap();
    send_item(make_item(OP_TICK, 2'd0, COL_OFF, 1'b0, 32'd500, 8'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_TICK, 2'd0, COL_OFF, 1'b0, 32'hFFFF_FFFF, 8'd0,
                        1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_TICK, 2'd0, COL_OFF, 1'b0, 32'd499, 8'd0, 1'b0, 1'b0, 1'b0));
    // Going solid clears the phase, so blinking again starts dark.
    send_item(make_item(OP_SET, 2'd3, COL_GREEN, 1'b0, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_SET, 2'd3, COL_GREEN, 1'b1, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    sender_gap();
    send_item(make_item(OP_POWER, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd0, 1'b0, 1'b1, 1'b1));
    send_item(make_item(OP_POWER, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd0, 1'b1, 1'b0, 1'b1));
    send_item(make_item(OP_POWER, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd0, 1'b1, 1'b1, 1'b1));
    send_item(make_item(OP_GPS, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd4, 1'b0, 1'b1, 1'b1));
    send_item(make_item(OP_GPS, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd0, 1'b1, 1'b0, 1'b0));
    sender_gap();
    send_item(make_item(OP_GPS, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd4, 1'b1, 1'b0, 1'b0));
    send_item(make_item(OP_GPS, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd5, 1'b1, 1'b0, 1'b0));
    send_item(make_item(OP_GPS, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd255, 1'b1, 1'b0, 1'b0));
    send_item(make_item(OP_STEER, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd0, 1'b0, 1'b1, 1'b1));
    send_item(make_item(OP_STEER, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd0, 1'b1, 1'b0, 1'b1));
    sender_gap();
    send_item(make_item(OP_STEER, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd0, 1'b1, 1'b1, 1'b0));
    send_item(make_item(OP_STEER, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd0, 1'b1, 1'b1, 1'b1));
    send_item(make_item(OP_IMU, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd0, 1'b0, 1'b1, 1'b1));
    send_item(make_item(OP_IMU, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd0, 1'b1, 1'b0, 1'b1));
    send_item(make_item(OP_IMU, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd0, 1'b1, 1'b1, 1'b0));
    send_item(make_item(OP_IMU, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd0, 1'b1, 1'b1, 1'b1));
    // The unused operation with every field at its top value must be ignored.
    send_item(make_item(OP_NONE, 2'd3, COL_GREEN, 1'b1, 32'hFFFF_FFFF, 8'd255,
                        1'b1, 1'b1, 1'b1));
    settle();

    // Lowest brightness and a zero interval: every blinking LED toggles on each tick.
    set_levels(8'd0, 16'd0);
    send_item(make_item(OP_SET, 2'd1, COL_RED, 1'b1, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_SET, 2'd2, COL_YELLOW, 1'b1, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_TICK, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_TICK, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_REFRESH, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    settle();

    sent = 0;
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin bright = 8'd255; ivl = 16'hFFFF; end
        1: begin bright = 8'd4;   ivl = 16'd1;    end
        2: begin bright = 8'd5;   ivl = 16'd2;    end
        3: begin
          bright   = 8'd101;
          ivl      = 16'($urandom_range(1, 50));
          clock_ms = 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
        end
        4: begin bright = 8'd99;  ivl = 16'd0;    end
        default: begin
          bright = 8'($urandom_range(0, 255));
          ivl    = 16'($urandom_range(0, 65535));
        end
      endcase
      set_levels(bright, ivl);
      // Brightness shows on the next refresh straight away.
      send_item(make_item(OP_REFRESH, 2'd0, COL_OFF, 1'b0, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0));
      while (sent < RandomItems * (p + 1) / PhaseCount) begin
        random_item(it);
        send_item(it);
        if (it.op != OP_NONE) sent++;
        sender_gap();
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending_updates.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
